@@ sv/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int ColW  = 7;
  localparam int RowW  = 5;
  localparam int AddrW = 13;
  localparam int DataW = 16;
  localparam int PosW  = 12;

  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharReturn  = 8'd13;

  localparam logic ReqPrint  = 1'b0;
  localparam logic ReqSetPos = 1'b1;

  localparam logic RegTextColor = 1'b0;
  localparam logic [7:0] TextColorReset = 8'd15;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [7:0] col;
    logic [7:0] row;
  } req_t;

  typedef struct packed {
    logic             mem_write;
    logic [AddrW-1:0] mem_addr;
    logic [DataW-1:0] mem_data;
    logic             cursor_write;
    logic [PosW-1:0]  cursor_pos;
    logic             accepted;
  } res_t;

  // handshake status between the pipeline stages
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

@@ sv/text_console_writer.sv @@
// Top level of the text console writer.
//
//   port group   dir  word contents
//   s_axis_*     in   tuser: req_type; tdata: char_code, col, row
//   m_axis_*     out  tuser: mem_write, cursor_write, accepted;
//                     tdata: mem_addr, mem_data, cursor_pos
//   APB          in   text_color at byte address 0
//
// One word per cycle sustained while m_axis_tready is high; each word passes
// through the input register, then the result register. The cursor is updated
// as a word moves from the input register into the result register, so the next word sees the new cursor.
// Reset: cursor to 0,0, text_color to 15, both stages empty.
// A stall on m_axis holds the result register and fills the input register,
// then drops s_axis_tready.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_code, col, row
  input  logic [0:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // mem_addr, mem_data, cursor_pos, zero fill
  output logic [2:0]  m_axis_tuser,   // mem_write, cursor_write, accepted
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tcw_pkg::req_t       in_word;
  tcw_pkg::req_t       stage_word;
  tcw_pkg::res_t       res;
  tcw_pkg::res_t       out_word;
  tcw_pkg::stage_ctl_t ctl;
  logic [7:0]          text_color;

  assign pready = 1'b1;

  assign in_word.req_type  = s_axis_tuser[0];
  assign in_word.char_code = s_axis_tdata[7:0];
  assign in_word.col       = s_axis_tdata[15:8];
  assign in_word.row       = s_axis_tdata[23:16];

  tcw_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .text_color (text_color)
  );

  tcw_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_word  (in_word),
    .take     (ctl.take),
    .valid    (ctl.valid),
    .word     (stage_word)
  );

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .word       (stage_word),
    .text_color (text_color),
    .res        (res)
  );

  tcw_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ctl.valid),
    .in_ready  (ctl.take),
    .in_word   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  assign m_axis_tdata = {7'd0, out_word.cursor_pos, out_word.mem_data, out_word.mem_addr};
  assign m_axis_tuser = {out_word.accepted, out_word.cursor_write, out_word.mem_write};

endmodule

@@ sv/tcw_cfg_regs.sv @@
// APB configuration register: text attribute byte.
module tcw_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [7:0]  text_color
);

  logic wr_en;

  assign wr_en = psel && penable && pwrite && (paddr[2] == tcw_pkg::RegTextColor);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::TextColorReset;
    end else if (wr_en) begin
      text_color <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == tcw_pkg::RegTextColor) ? {24'd0, text_color} : 32'd0;

endmodule

@@ sv/tcw_in_stage.sv @@
// Input register: holds one request word until the cursor stage takes it.
module tcw_in_stage (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  tcw_pkg::req_t in_word,
  input  logic         take,
  output logic         valid,
  output tcw_pkg::req_t word
);

  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= in_word;
    end
  end

endmodule

@@ sv/tcw_cursor.sv @@
// Cursor state and per-request result logic.
module tcw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  tcw_pkg::stage_ctl_t ctl,
  input  tcw_pkg::req_t      word,
  input  logic [7:0]         text_color,
  output tcw_pkg::res_t      res
);

  localparam logic [7:0] ColLimit = 8'(COLUMNS);
  localparam logic [7:0] RowLimit = 8'(ROWS);
  localparam logic [tcw_pkg::PosW-1:0] ColMul = tcw_pkg::PosW'(COLUMNS);

  logic [tcw_pkg::ColW-1:0] cursor_col;
  logic [tcw_pkg::RowW-1:0] cursor_row;

  logic                     is_print;
  logic                     in_bounds;
  logic [7:0]               adv_col;
  logic [7:0]               adv_row;
  logic [7:0]               tgt_col;
  logic [7:0]               tgt_row;
  logic                     pos_ok;
  logic [tcw_pkg::PosW-1:0] cell_idx;
  logic [tcw_pkg::PosW-1:0] tgt_idx;
  logic [tcw_pkg::PosW:0]   cell_byte;

  assign is_print = (word.req_type == tcw_pkg::ReqPrint) &&
                    (word.char_code != tcw_pkg::CharNewline) &&
                    (word.char_code != tcw_pkg::CharReturn);

  assign in_bounds = ({1'b0, cursor_col} <= ColLimit) && ({3'd0, cursor_row} <= RowLimit);

  always_comb begin
    adv_col = {1'b0, cursor_col} + 8'd1;
    adv_row = {3'd0, cursor_row};
    if (adv_col == ColLimit) begin
      adv_col = 8'd0;
      adv_row = adv_row + 8'd1;
    end
    if (!in_bounds) begin
      adv_col = {1'b0, cursor_col};
      adv_row = {3'd0, cursor_row};
    end
  end

  always_comb begin
    if (word.req_type == tcw_pkg::ReqSetPos) begin
      tgt_col = word.col;
      tgt_row = word.row;
    end else if (!is_print) begin
      tgt_col = 8'd0;
      tgt_row = {3'd0, cursor_row} + 8'd1;
    end else begin
      tgt_col = adv_col;
      tgt_row = adv_row;
    end
  end

  assign pos_ok = (tgt_col <= ColLimit) && (tgt_row <= RowLimit);

  assign cell_idx  = tcw_pkg::PosW'(cursor_row) * ColMul + tcw_pkg::PosW'(cursor_col);
  assign tgt_idx   = tcw_pkg::PosW'(tgt_row[tcw_pkg::RowW-1:0]) * ColMul +
                     tcw_pkg::PosW'(tgt_col[tcw_pkg::ColW-1:0]);
  assign cell_byte = {cell_idx, 1'b0};

  always_comb begin
    res = '0;
    res.cursor_write = pos_ok;
    res.cursor_pos   = pos_ok ? tgt_idx : '0;
    if (is_print) begin
      res.mem_write = in_bounds;
      res.accepted  = in_bounds;
      if (in_bounds) begin
        res.mem_addr = cell_byte[tcw_pkg::AddrW-1:0];
        res.mem_data = {text_color, word.char_code};
      end
    end else begin
      res.accepted = pos_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (ctl.valid && ctl.take && pos_ok) begin
      cursor_col <= tgt_col[tcw_pkg::ColW-1:0];
      cursor_row <= tgt_row[tcw_pkg::RowW-1:0];
    end
  end

endmodule

@@ sv/tcw_out_stage.sv @@
// Result register toward the output stream.
module tcw_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tcw_pkg::res_t in_word,
  output logic          out_valid,
  input  logic          out_ready,
  output tcw_pkg::res_t out_word
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_word <= in_word;
    end
  end

endmodule

@@ sv/tcw_checker.sv @@
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  a_write_accepted: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]) |-> m_axis_tuser[2])
    else $error("write flag without accepted");

  a_accepted_acts: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[0] || m_axis_tuser[1])
    else $error("accepted without any write");

  a_idle_cell_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[28:0] == 29'd0)
    else $error("cell fields nonzero without mem_write");

  a_idle_cursor_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[40:29] == 12'd0)
    else $error("cursor_pos nonzero without cursor_write");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed under stall");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/tb_text_console_writer.sv @@
// Testbench for text_console_writer: random and directed words checked against a cursor model.
`timescale 1ns / 100ps

module tb_text_console_writer;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int WatchLimit = 5000;
  localparam int HoldCycles = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic [31:0] prdata;
  logic        pready;

  // cursor and color as the block should hold them
  logic [tcw_pkg::ColW-1:0] model_col   = '0;
  logic [tcw_pkg::RowW-1:0] model_row   = '0;
  logic [7:0]               model_color = tcw_pkg::TextColorReset;

  tcw_pkg::res_t awaited_outputs[$];
  int   fail_count   = 0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   hold_id      = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic tcw_pkg::res_t predict_output(tcw_pkg::req_t rq);
    tcw_pkg::res_t o;
    int unsigned c;
    int unsigned r;
    logic        wrote;
    logic        is_move;
    o       = '0;
    wrote   = 1'b0;
    is_move = 1'b1;
    c       = model_col;
    r       = model_row;
    if (rq.req_type == tcw_pkg::ReqSetPos) begin
      c = rq.col;
      r = rq.row;
    end else if (rq.char_code == tcw_pkg::CharNewline ||
                 rq.char_code == tcw_pkg::CharReturn) begin
      c = 0;
      r = model_row + 1;
    end else begin
      is_move = 1'b0;
      if (c <= COLUMNS && r <= ROWS) begin
        wrote      = 1'b1;
        o.mem_write = 1'b1;
        o.mem_addr  = tcw_pkg::AddrW'((r * COLUMNS + c) * 2);
        o.mem_data  = {model_color, rq.char_code};
        c++;
        if (c == COLUMNS) begin
          c = 0;
          r++;
        end
      end
    end
    if (c <= COLUMNS && r <= ROWS) begin
      model_col      = tcw_pkg::ColW'(c);
      model_row      = tcw_pkg::RowW'(r);
      o.cursor_write = 1'b1;
      o.cursor_pos   = tcw_pkg::PosW'(r * COLUMNS + c);
    end
    o.accepted = is_move ? o.cursor_write : wrote;
    return o;
  endfunction

  function automatic tcw_pkg::req_t mk_req(logic kind, logic [7:0] ch, logic [7:0] c,
                                           logic [7:0] r);
    tcw_pkg::req_t rq;
    rq.req_type  = kind;
    rq.char_code = ch;
    rq.col       = c;
    rq.row       = r;
    return rq;
  endfunction

  // mostly text, some line breaks, positions biased toward the edges
  function automatic tcw_pkg::req_t random_request();
    tcw_pkg::req_t rq;
    int   k;
    rq = mk_req(tcw_pkg::ReqPrint, 8'($urandom), 8'($urandom), 8'($urandom));
    k  = $urandom_range(99);
    if (k >= 60 && k < 68) begin
      rq.char_code = $urandom_range(1) ? tcw_pkg::CharNewline : tcw_pkg::CharReturn;
    end else if (k >= 68 && k < 88) begin
      rq.req_type = tcw_pkg::ReqSetPos;
      rq.col = $urandom_range(1) ? 8'($urandom_range(COLUMNS, COLUMNS - 10))
                                 : 8'($urandom_range(COLUMNS));
      rq.row = $urandom_range(1) ? 8'($urandom_range(ROWS, ROWS - 5))
                                 : 8'($urandom_range(ROWS));
    end else if (k >= 88) begin
      rq.req_type = tcw_pkg::ReqSetPos;
    end
    return rq;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  task automatic send_request(tcw_pkg::req_t rq);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_tuser <= rq.req_type;
    s_tdata <= {rq.row, rq.col, rq.char_code};
    do @(posedge clk); while (!s_axis_tready);
    awaited_outputs.push_back(predict_output(rq));
  endtask

  task automatic drain_stream();
    s_valid <= 1'b0;
    @(posedge clk);
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write, then read back text_color
  task automatic write_color(logic [2:0] addr, logic [7:0] value);
    logic [31:0] rd;
    apb_access(1'b1, addr, {$urandom_range(1) ? 24'hFFFFFF : 24'h0, value}, rd);
    if ((addr >> 2) == 3'(tcw_pkg::RegTextColor)) model_color = value;
    apb_access(1'b0, 3'(tcw_pkg::RegTextColor) << 2, 32'h0, rd);
    check_field("prdata", {24'h0, model_color}, rd);
  endtask

  task automatic test_directed();
    tcw_pkg::req_t dir_q[$];
    dir_q = '{
      mk_req(tcw_pkg::ReqPrint,  8'h41, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqPrint,  8'h00, 8'hFF, 8'hFF),
      mk_req(tcw_pkg::ReqPrint,  8'hFF, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqPrint,  tcw_pkg::CharNewline, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqPrint,  tcw_pkg::CharReturn, 8'hFF, 8'hFF),
      mk_req(tcw_pkg::ReqSetPos, 8'hFF, 8'(COLUMNS), 8'(ROWS)),
      mk_req(tcw_pkg::ReqPrint,  8'h55, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqPrint,  8'hAA, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqPrint,  tcw_pkg::CharNewline, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqSetPos, 8'h00, 8'(COLUMNS + 1), 8'h00),
      mk_req(tcw_pkg::ReqSetPos, 8'h00, 8'h00, 8'(ROWS + 1)),
      mk_req(tcw_pkg::ReqSetPos, 8'h00, 8'hFF, 8'hFF),
      mk_req(tcw_pkg::ReqSetPos, 8'h00, 8'(COLUMNS - 1), 8'(ROWS)),
      mk_req(tcw_pkg::ReqPrint,  8'h7E, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqSetPos, tcw_pkg::CharNewline, 8'(COLUMNS - 1), 8'(ROWS - 1)),
      mk_req(tcw_pkg::ReqPrint,  8'h80, 8'hFF, 8'hFF),
      mk_req(tcw_pkg::ReqPrint,  tcw_pkg::CharReturn, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqSetPos, 8'h00, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqSetPos, 8'h00, 8'(COLUMNS), 8'h00),
      mk_req(tcw_pkg::ReqPrint,  8'h21, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqPrint,  tcw_pkg::CharNewline, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqPrint,  8'h0B, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqPrint,  8'h0C, 8'h00, 8'h00),
      mk_req(tcw_pkg::ReqPrint,  8'h0E, 8'h00, 8'h00)
    };
    src_idle_pct = 20;
    snk_idle_pct = 20;
    foreach (dir_q[i]) send_request(dir_q[i]);
    drain_stream();
  endtask

  task automatic test_color_register();
    write_color(3'(tcw_pkg::RegTextColor) << 2, 8'h00);
    send_request(mk_req(tcw_pkg::ReqPrint, 8'h5A, 8'h00, 8'h00));
    drain_stream();
    // index 1 is not a register
    write_color(3'd4, 8'($urandom));
    send_request(mk_req(tcw_pkg::ReqPrint, 8'h5B, 8'h00, 8'h00));
    drain_stream();
    write_color(3'(tcw_pkg::RegTextColor) << 2, 8'hFF);
    send_request(mk_req(tcw_pkg::ReqPrint, 8'h5C, 8'h00, 8'h00));
    drain_stream();
  endtask

  task automatic test_random_traffic(int src_pct, int snk_pct, int count);
    write_color(3'(tcw_pkg::RegTextColor) << 2, 8'($urandom));
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (count) send_request(random_request());
    drain_stream();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_id++;
    repeat (40) send_request(random_request());
    drain_stream();
  endtask

  // receiver: check each word, then pick next tready
  always @(posedge clk) begin : rx_side
    tcw_pkg::res_t want;
    tcw_pkg::res_t got;
    if (!rst && m_axis_tvalid && m_tready) begin
      got.mem_write    = m_axis_tuser[0];
      got.cursor_write = m_axis_tuser[1];
      got.accepted     = m_axis_tuser[2];
      got.mem_addr     = m_axis_tdata[12:0];
      got.mem_data     = m_axis_tdata[28:13];
      got.cursor_pos   = m_axis_tdata[40:29];
      if (awaited_outputs.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h/%h", $time,
                 m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = awaited_outputs.pop_front();
        check_field("mem_write", want.mem_write, got.mem_write);
        check_field("mem_addr", want.mem_addr, got.mem_addr);
        check_field("mem_data", want.mem_data, got.mem_data);
        check_field("cursor_write", want.cursor_write, got.cursor_write);
        check_field("cursor_pos", want.cursor_pos, got.cursor_pos);
        check_field("accepted", want.accepted, got.accepted);
        check_field("tdata fill", 32'h0, m_axis_tdata[47:41]);
      end
    end
    if (hold_seen != hold_id) begin
      hold_seen <= hold_id;
      hold_left <= HoldCycles;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_valid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_color_register();
    test_random_traffic(33, 84, 570);
    test_random_traffic(84, 33, 570);
    test_random_traffic(0, 0, 570);
    test_backpressure();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
